// ----- sv/spi_angle_encoder_poller_assert.svh -----
// ----------------------------------------------------------------------------
// spi angle encoder poller assertion macros
// shared concurrent assertion forms for the poller rtl
// ----------------------------------------------------------------------------
`ifndef SPI_ANGLE_ENCODER_POLLER_ASSERT_SVH
`define SPI_ANGLE_ENCODER_POLLER_ASSERT_SVH

// same-cycle implication
`define SAEP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("saep same-cycle check failed");

// next-cycle implication
`define SAEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("saep next-cycle check failed");

`endif

// ----- sv/saep_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saep_pkg
// types and command constants for the spi angle encoder poller
// ----------------------------------------------------------------------------
package saep_pkg;

   localparam logic [15:0] CMD_CLEAR_ERRORS = 16'h4001;
   localparam logic [15:0] CMD_DIAG_ADDRESS = 16'h7FFD;
   localparam logic [15:0] CMD_READ_ANGLE   = 16'hFFFF;
   localparam logic [13:0] ANGLE_MASK       = 14'h3FFF;

   // diagnostic flag positions in the reply word
   localparam int unsigned DIAG_WEAK_BIT   = 11;
   localparam int unsigned DIAG_STRONG_BIT = 10;
   localparam int unsigned DIAG_CORDIC_BIT = 9;
   localparam int unsigned DIAG_OCF_BIT    = 8;

   localparam logic MODE_POLL  = 1'b0;
   localparam logic MODE_FRAME = 1'b1;

   typedef enum logic [5:0] {
      PH_CLEAR      = 6'b000001,
      PH_WAIT_CLEAR = 6'b000010,
      PH_SEND_ANGLE = 6'b000100,
      PH_WAIT_ANGLE = 6'b001000,
      PH_SEND_DIAG  = 6'b010000,
      PH_WAIT_DIAG  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic        mode;
      logic [15:0] rx_word;
   } req_word_type;

   typedef struct packed {
      logic        tx_valid;
      logic [15:0] tx_word;
      logic [13:0] angle;
      logic        angle_updated;
      logic        parity_error;
      logic        magnet_error;
      logic        alarm_led;
      logic        motor_disable;
   } rsp_word_type;

   typedef struct packed {
      phase_type   phase;
      logic [13:0] angle;
      logic        parity_fault;
      logic        magnet_fault;
      logic        lamp;
   } state_type;

endpackage

// ----- sv/saep_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saep_step
// one rotation step: next sequencer state and the result word for an item
// ----------------------------------------------------------------------------
module saep_step (
   input  saep_pkg::state_type    cur,
   input  saep_pkg::req_word_type req,
   output saep_pkg::state_type    nxt,
   output saep_pkg::rsp_word_type rsp
);

   logic        tx_valid;
   logic [15:0] tx_word;
   logic        updated;
   logic        mdis;
   logic        parity_good;
   logic        diag_bad;

   assign parity_good = ~(^req.rx_word);
   assign diag_bad = req.rx_word[saep_pkg::DIAG_WEAK_BIT]
                   | req.rx_word[saep_pkg::DIAG_STRONG_BIT]
                   | req.rx_word[saep_pkg::DIAG_CORDIC_BIT]
                   | ~req.rx_word[saep_pkg::DIAG_OCF_BIT];

   always_comb begin
      nxt      = cur;
      tx_valid = 1'b0;
      tx_word  = 16'h0000;
      updated  = 1'b0;
      mdis     = 1'b0;
      unique case (cur.phase)
         saep_pkg::PH_WAIT_CLEAR: begin
            if (req.mode == saep_pkg::MODE_FRAME) begin
               tx_valid  = 1'b1;
               tx_word   = saep_pkg::CMD_DIAG_ADDRESS;
               nxt.phase = saep_pkg::PH_WAIT_ANGLE;
            end
         end
         saep_pkg::PH_SEND_ANGLE: begin
            tx_valid = 1'b1;
            if (req.mode == saep_pkg::MODE_FRAME) begin
               // unexpected frame restarts the rotation
               tx_word   = saep_pkg::CMD_CLEAR_ERRORS;
               nxt.phase = saep_pkg::PH_WAIT_CLEAR;
            end else begin
               tx_word   = saep_pkg::CMD_DIAG_ADDRESS;
               nxt.phase = saep_pkg::PH_WAIT_ANGLE;
            end
         end
         saep_pkg::PH_WAIT_ANGLE: begin
            if (req.mode == saep_pkg::MODE_FRAME) begin
               if (parity_good) begin
                  nxt.parity_fault = 1'b0;
                  nxt.angle        = req.rx_word[13:0] & saep_pkg::ANGLE_MASK;
                  updated          = 1'b1;
                  nxt.phase        = saep_pkg::PH_SEND_DIAG;
               end else begin
                  nxt.parity_fault = 1'b1;
                  mdis             = 1'b1;
                  nxt.phase        = saep_pkg::PH_CLEAR;
               end
            end
         end
         saep_pkg::PH_SEND_DIAG: begin
            tx_valid = 1'b1;
            if (req.mode == saep_pkg::MODE_FRAME) begin
               tx_word   = saep_pkg::CMD_CLEAR_ERRORS;
               nxt.phase = saep_pkg::PH_WAIT_CLEAR;
            end else begin
               tx_word   = saep_pkg::CMD_READ_ANGLE;
               nxt.phase = saep_pkg::PH_WAIT_DIAG;
            end
         end
         saep_pkg::PH_WAIT_DIAG: begin
            if (req.mode == saep_pkg::MODE_FRAME) begin
               nxt.magnet_fault = diag_bad;
               nxt.lamp         = diag_bad;
               nxt.phase        = saep_pkg::PH_SEND_ANGLE;
            end
         end
         default: begin
            // clear-errors step, either kind of item
            tx_valid  = 1'b1;
            tx_word   = saep_pkg::CMD_CLEAR_ERRORS;
            nxt.phase = saep_pkg::PH_WAIT_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp.tx_valid      = tx_valid;
      rsp.tx_word       = tx_word;
      rsp.angle         = nxt.angle;
      rsp.angle_updated = updated;
      rsp.parity_error  = nxt.parity_fault;
      rsp.magnet_error  = nxt.magnet_fault;
      rsp.alarm_led     = nxt.lamp;
      rsp.motor_disable = mdis;
   end

endmodule

// ----- sv/spi_angle_encoder_poller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_angle_encoder_poller
// readout sequencer for a 16-bit spi magnetic angle encoder
// ----------------------------------------------------------------------------
// usage
//   req channel: one word per software poll (mode 0) or per finished spi
//   frame (mode 1, rx_word holds the received word)
//   rsp channel: exactly one word per req word, carrying the command to send
//   (tx_valid, tx_word), the stored angle and the status flags
//   path: an accepted req word waits in the input register, then passes
//   through the sequencer into the result register, which drives rsp
//   throughput: one word per cycle while rsp_stall is low, set by the
//   single-step sequencer that sits between the two registers
//   stall: rsp_stall holds the result register; the input register keeps
//   taking one more word, then req_stall rises until the result moves on
//   reset: synchronous, clears both stages and returns the rotation to the
//   clear-errors step with angle and flags at zero
// ----------------------------------------------------------------------------
module spi_angle_encoder_poller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  saep_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output saep_pkg::rsp_word_type rsp_word
);

`include "spi_angle_encoder_poller_assert.svh"

   // input stage
   logic                   s1_valid_ff, s1_valid_in;
   saep_pkg::req_word_type s1_word_ff;

   // result stage
   logic                   s2_valid_ff, s2_valid_in;
   saep_pkg::rsp_word_type s2_word_ff;

   // sequencer state
   saep_pkg::state_type    state_ff;
   saep_pkg::state_type    state_in;
   saep_pkg::rsp_word_type step_rsp;

   logic s1_move;
   logic req_take;

   // input word moves on when the result register is free or draining
   assign s1_move  = s1_valid_ff & (~s2_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~s1_move;
   assign req_take = req_valid & ~req_stall;

   assign s1_valid_in = req_take | (s1_valid_ff & ~s1_move);
   assign s2_valid_in = s1_move | (s2_valid_ff & rsp_stall);

   saep_step u_step (
      .cur (state_ff),
      .req (s1_word_ff),
      .nxt (state_in),
      .rsp (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff           <= 1'b0;
         s2_valid_ff           <= 1'b0;
         state_ff.phase        <= saep_pkg::PH_CLEAR;
         state_ff.angle        <= 14'h0000;
         state_ff.parity_fault <= 1'b0;
         state_ff.magnet_fault <= 1'b0;
         state_ff.lamp         <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         // state advances only when an item is actually processed
         if (s1_move) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_word;
      end
      if (s1_move) begin
         s2_word_ff <= step_rsp;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_word  = s2_word_ff;

   // a parity failure never starts a frame in the same word
   `SAEP_ASSERT_SAME(a_mdis_no_tx, clock, reset, rsp_valid && rsp_word.motor_disable,
      !rsp_word.tx_valid && rsp_word.parity_error)
   // a fresh angle always comes with parity error cleared
   `SAEP_ASSERT_SAME(a_update_clears_parity, clock, reset,
      rsp_valid && rsp_word.angle_updated, !rsp_word.parity_error)
   // an accepted request lands in the input stage
   `SAEP_ASSERT_NEXT(a_take_fills_s1, clock, reset, req_take, s1_valid_ff)
   // a processed item is shown on the result side next cycle
   `SAEP_ASSERT_NEXT(a_move_fills_s2, clock, reset, s1_move, rsp_valid)

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the spi angle encoder poller: a burst driver sends
// polls and finished frames, mostly in the order the readout rotation wants,
// a shadow sequencer predicts every status word, and a monitor compares each
// accepted status word field by field while the receiver stalls at random
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned RANDOM_WORDS = 1450;
   localparam int unsigned CYCLE_LIMIT  = 500000;
   // two register stages inside, plus margin
   localparam int unsigned DRAIN_CYCLES = 20;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_RUNS
   } stall_pattern_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   saep_pkg::req_word_type req_word;
   logic                   rsp_valid;
   logic                   rsp_stall;
   saep_pkg::rsp_word_type rsp_word;

   // words waiting to be driven, and status words still owed by the block
   saep_pkg::req_word_type queued_requests[$];
   saep_pkg::rsp_word_type owed_status[$];

   // rotation seen by the generator and rotation tracked at acceptance
   saep_pkg::state_type gen_rotation;
   saep_pkg::state_type live_rotation;

   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned burst_left;
   int unsigned gap_left;

   stall_pattern_type stall_pattern;
   int unsigned       pattern_left;
   int unsigned       run_left;
   logic              run_stall;

   spi_angle_encoder_poller uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // -------------------------------------------------------------------------
   // shadow sequencer
   // -------------------------------------------------------------------------

   task automatic clear_rotation(output saep_pkg::state_type st);
      st.phase        = saep_pkg::PH_CLEAR;
      st.angle        = '0;
      st.parity_fault = 1'b0;
      st.magnet_fault = 1'b0;
      st.lamp         = 1'b0;
   endtask

   // one poll or finished frame through the rotation, giving its status word
   task automatic step_rotation(inout saep_pkg::state_type st,
                                input saep_pkg::req_word_type w,
                                output saep_pkg::rsp_word_type r);
      r = '0;
      if (w.mode == saep_pkg::MODE_POLL) begin
         case (st.phase)
            saep_pkg::PH_SEND_ANGLE: begin
               r.tx_valid = 1'b1;
               r.tx_word  = saep_pkg::CMD_DIAG_ADDRESS;
               st.phase   = saep_pkg::PH_WAIT_ANGLE;
            end
            saep_pkg::PH_SEND_DIAG: begin
               r.tx_valid = 1'b1;
               r.tx_word  = saep_pkg::CMD_READ_ANGLE;
               st.phase   = saep_pkg::PH_WAIT_DIAG;
            end
            saep_pkg::PH_WAIT_CLEAR, saep_pkg::PH_WAIT_ANGLE, saep_pkg::PH_WAIT_DIAG: begin
               // a frame is still in flight, poll does nothing
            end
            default: begin
               r.tx_valid = 1'b1;
               r.tx_word  = saep_pkg::CMD_CLEAR_ERRORS;
               st.phase   = saep_pkg::PH_WAIT_CLEAR;
            end
         endcase
      end else begin
         case (st.phase)
            saep_pkg::PH_WAIT_CLEAR: begin
               r.tx_valid = 1'b1;
               r.tx_word  = saep_pkg::CMD_DIAG_ADDRESS;
               st.phase   = saep_pkg::PH_WAIT_ANGLE;
            end
            saep_pkg::PH_WAIT_ANGLE: begin
               // even parity over the whole reply
               if (^w.rx_word == 1'b0) begin
                  st.parity_fault = 1'b0;
                  st.angle        = w.rx_word[13:0];
                  r.angle_updated = 1'b1;
                  st.phase        = saep_pkg::PH_SEND_DIAG;
               end else begin
                  st.parity_fault = 1'b1;
                  r.motor_disable = 1'b1;
                  st.phase        = saep_pkg::PH_CLEAR;
               end
            end
            saep_pkg::PH_WAIT_DIAG: begin
               st.magnet_fault = w.rx_word[saep_pkg::DIAG_WEAK_BIT]
                               | w.rx_word[saep_pkg::DIAG_STRONG_BIT]
                               | w.rx_word[saep_pkg::DIAG_CORDIC_BIT]
                               | ~w.rx_word[saep_pkg::DIAG_OCF_BIT];
               st.lamp         = st.magnet_fault;
               st.phase        = saep_pkg::PH_SEND_ANGLE;
            end
            default: begin
               // frame out of turn restarts the rotation
               r.tx_valid = 1'b1;
               r.tx_word  = saep_pkg::CMD_CLEAR_ERRORS;
               st.phase   = saep_pkg::PH_WAIT_CLEAR;
            end
         endcase
      end
      r.angle        = st.angle;
      r.parity_error = st.parity_fault;
      r.magnet_error = st.magnet_fault;
      r.alarm_led    = st.lamp;
   endtask

   // -------------------------------------------------------------------------
   // stimulus generation
   // -------------------------------------------------------------------------

   // queue one word; counted is low for a poll the rotation just sits out
   task automatic queue_word(input logic mode, input logic [15:0] rx,
                             output bit counted);
      saep_pkg::req_word_type w;
      saep_pkg::rsp_word_type unused;
      w.mode    = mode;
      w.rx_word = rx;
      counted   = !(mode == saep_pkg::MODE_POLL &&
                    (gen_rotation.phase == saep_pkg::PH_WAIT_CLEAR ||
                     gen_rotation.phase == saep_pkg::PH_WAIT_ANGLE ||
                     gen_rotation.phase == saep_pkg::PH_WAIT_DIAG));
      queued_requests.push_back(w);
      step_rotation(gen_rotation, w, unused);
   endtask

   // mostly the word the rotation waits for, with random content, some noise
   task automatic queue_random_word(output bit counted);
      logic [15:0] rx;
      logic [3:0]  flags;
      rx = 16'($urandom);
      if ($urandom_range(0, 99) < 10) begin
         queue_word(1'($urandom), rx, counted);
      end else begin
         case (gen_rotation.phase)
            saep_pkg::PH_WAIT_CLEAR: queue_word(saep_pkg::MODE_FRAME, rx, counted);
            saep_pkg::PH_WAIT_ANGLE: begin
               // bit 15 carries the parity, steer it to good or bad
               if ((^rx) != ($urandom_range(0, 99) < 15))
                  rx[15] = ~rx[15];
               queue_word(saep_pkg::MODE_FRAME, rx, counted);
            end
            saep_pkg::PH_WAIT_DIAG: begin
               case ($urandom_range(0, 3))
                  0, 1: flags = 4'b0001;
                  2:    flags = 4'($urandom);
                  default: begin
                     case ($urandom_range(0, 3))
                        0: flags = 4'b1001;
                        1: flags = 4'b0101;
                        2: flags = 4'b0011;
                        default: flags = 4'b0000;
                     endcase
                  end
               endcase
               rx[11:8] = flags;
               queue_word(saep_pkg::MODE_FRAME, rx, counted);
            end
            default: queue_word(saep_pkg::MODE_POLL, rx, counted);
         endcase
      end
   endtask

   // -------------------------------------------------------------------------
   // clock, reset and the run
   // -------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      bit          counted;
      int unsigned random_done;
      reset       = 1'b1;
      error_count = 0;
      random_done = 0;
      clear_rotation(gen_rotation);
      clear_rotation(live_rotation);

      // directed walk: full rotation, ignored polls, extreme angles,
      // all diagnostic faults, bad parity and frames out of turn
      queue_word(saep_pkg::MODE_POLL,  16'h0000, counted);   // clear-errors command
      queue_word(saep_pkg::MODE_POLL,  16'hFFFF, counted);   // poll while waiting
      queue_word(saep_pkg::MODE_FRAME, 16'hABCD, counted);   // clear done, ask for angle
      queue_word(saep_pkg::MODE_POLL,  16'h0000, counted);
      queue_word(saep_pkg::MODE_FRAME, 16'h0000, counted);   // lowest angle
      queue_word(saep_pkg::MODE_POLL,  16'h0000, counted);   // read-angle command
      queue_word(saep_pkg::MODE_POLL,  16'h0000, counted);
      queue_word(saep_pkg::MODE_FRAME, 16'h0100, counted);   // clean diagnostic
      queue_word(saep_pkg::MODE_POLL,  16'h0000, counted);
      queue_word(saep_pkg::MODE_FRAME, 16'hFFFF, counted);   // highest angle
      queue_word(saep_pkg::MODE_POLL,  16'h0000, counted);
      queue_word(saep_pkg::MODE_FRAME, 16'h0E00, counted);   // every fault flag
      queue_word(saep_pkg::MODE_FRAME, 16'h5555, counted);   // frame while sending
      queue_word(saep_pkg::MODE_FRAME, 16'h0000, counted);
      queue_word(saep_pkg::MODE_FRAME, 16'h0001, counted);   // odd parity
      queue_word(saep_pkg::MODE_FRAME, 16'h0000, counted);   // frame in clear step
      queue_word(saep_pkg::MODE_FRAME, 16'h0000, counted);
      queue_word(saep_pkg::MODE_FRAME, 16'h8001, counted);   // good again, fault clears
      queue_word(saep_pkg::MODE_FRAME, 16'h0000, counted);   // frame in diagnostic send
      queue_word(saep_pkg::MODE_FRAME, 16'h0000, counted);
      queue_word(saep_pkg::MODE_FRAME, 16'h7FFF, counted);   // odd parity, top bit low
      queue_word(saep_pkg::MODE_POLL,  16'h0000, counted);
      queue_word(saep_pkg::MODE_FRAME, 16'h0000, counted);
      queue_word(saep_pkg::MODE_FRAME, 16'h3FFF, counted);
      queue_word(saep_pkg::MODE_POLL,  16'h0000, counted);
      queue_word(saep_pkg::MODE_FRAME, 16'h0000, counted);   // offset not finished

      while (random_done < RANDOM_WORDS) begin
         queue_random_word(counted);
         if (counted)
            random_done++;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // sample between edges so the driver and monitor have settled
      while (queued_requests.size() != 0 || req_valid || owed_status.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && owed_status.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hard stop for a hung handshake or a lost status word
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // driver: bursts of words with random gaps
   // -------------------------------------------------------------------------

   always @(posedge clock) begin : driver
      saep_pkg::req_word_type next_word;
      saep_pkg::rsp_word_type owed;
      logic                   showing;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         showing = req_valid;
         // word taken at this edge, predict its status now
         if (req_valid && !req_stall) begin
            step_rotation(live_rotation, req_word, owed);
            owed_status.push_back(owed);
            showing = 1'b0;
         end
         // a stalled word stays put, otherwise choose the next one
         if (!showing) begin
            next_word = req_word;
            if (gap_left > 0) begin
               gap_left--;
            end else if (queued_requests.size() != 0) begin
               next_word = queued_requests.pop_front();
               showing   = 1'b1;
               if (burst_left > 0)
                  burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  // back-to-back bursts now and then
                  gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
               end
            end
            req_valid <= showing;
            req_word  <= next_word;
         end
      end
   end

   // -------------------------------------------------------------------------
   // receiver stall: pattern switches between none, coin flips and long runs
   // -------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall     <= 1'b0;
         stall_pattern = STALL_NONE;
         pattern_left  = 64;
         run_left      = 0;
         run_stall     = 1'b0;
      end else begin
         if (pattern_left == 0) begin
            stall_pattern = stall_pattern_type'($urandom_range(0, 2));
            pattern_left  = $urandom_range(32, 256);
         end else begin
            pattern_left--;
         end
         case (stall_pattern)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_COIN: rsp_stall <= 1'($urandom);
            default: begin
               if (run_left == 0) begin
                  run_stall = ~run_stall;
                  run_left  = $urandom_range(1, 16);
               end else begin
                  run_left--;
               end
               rsp_stall <= run_stall;
            end
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // monitor: each accepted status word against the oldest owed one
   // -------------------------------------------------------------------------

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      saep_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_status.size() == 0) begin
            $error("status word with none owed: %0h", rsp_word);
            error_count++;
         end else begin
            want = owed_status.pop_front();
            check_field("tx_valid",      16'(want.tx_valid),      16'(rsp_word.tx_valid));
            check_field("tx_word",       want.tx_word,            rsp_word.tx_word);
            check_field("angle",         16'(want.angle),         16'(rsp_word.angle));
            check_field("angle_updated", 16'(want.angle_updated), 16'(rsp_word.angle_updated));
            check_field("parity_error",  16'(want.parity_error),  16'(rsp_word.parity_error));
            check_field("magnet_error",  16'(want.magnet_error),  16'(rsp_word.magnet_error));
            check_field("alarm_led",     16'(want.alarm_led),     16'(rsp_word.alarm_led));
            check_field("motor_disable", 16'(want.motor_disable), 16'(rsp_word.motor_disable));
         end
      end
   end

endmodule
